// ----- hw/rtl/anh_pkg.sv -----
// shared types and constants for the archive name hash block
package anh_pkg;

    localparam logic [31:0] TAIL_WORD_0 = 32'h9BE7_4448;
    localparam logic [31:0] TAIL_WORD_1 = 32'h66F4_2C48;
    localparam logic [31:0] KEY_INIT    = 32'hF4FA_8928;
    localparam logic [31:0] X_INIT      = 32'h37A8_470E;
    localparam logic [31:0] Y_INIT      = 32'h7758_B42B;
    localparam logic [31:0] W_BASE      = 32'h267B_0B11;
    localparam logic [31:0] MASK_A      = 32'h0204_0801;
    localparam logic [31:0] MASK_C      = 32'hBFEF_7FDF;
    localparam logic [31:0] MASK_B      = 32'h0080_4021;
    localparam logic [31:0] MASK_D      = 32'h7DFE_FBFF;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // word source of a round
    localparam logic [1:0] SRC_WORD  = 2'd0;
    localparam logic [1:0] SRC_TAIL0 = 2'd1;
    localparam logic [1:0] SRC_TAIL1 = 2'd2;

    typedef struct packed {
        logic       take_byte;  // pack the accepted byte
        logic       prep;       // key step, xor word, build multiplicands
        logic       mulx;       // multiply for x
        logic       muly;       // finish x, multiply for y
        logic       finy;       // finish y
        logic       finish;     // load hash, restore state
        logic [1:0] src;
    } anh_cmd_t;

    typedef struct packed {
        logic byte_zero;   // request holds the terminator
        logic word_full;   // this byte completes a word
        logic partial;     // bytes held in the word buffer
        logic out_free;    // output register can take a hash
    } anh_status_t;

endpackage

// ----- hw/rtl/anh_ctrl.sv -----
// controller state machine sequencing byte intake and word rounds
module anh_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  anh_pkg::anh_status_t status,
    output anh_pkg::anh_cmd_t    cmd
);
    import anh_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MULX = 3'd2;
    localparam logic [2:0] ST_MULY = 3'd3;
    localparam logic [2:0] ST_FINY = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] src_reg, src_next;
    logic       term_reg, term_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        src_next   = src_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.src    = src_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (status.byte_zero) begin
                        term_next  = 1'b1;
                        src_next   = status.partial ? SRC_WORD : SRC_TAIL0;
                        state_next = ST_PREP;
                    end else begin
                        cmd.take_byte = 1'b1;
                        if (status.word_full) begin
                            term_next  = 1'b0;
                            src_next   = SRC_WORD;
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MULX;
            end
            ST_MULX: begin
                cmd.mulx   = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY: begin
                cmd.muly   = 1'b1;
                state_next = ST_FINY;
            end
            ST_FINY: begin
                cmd.finy = 1'b1;
                case (src_reg)
                    SRC_WORD: begin
                        if (term_reg) begin
                            src_next   = SRC_TAIL0;
                            state_next = ST_PREP;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    SRC_TAIL0: begin
                        src_next   = SRC_TAIL1;
                        state_next = ST_PREP;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    term_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            src_reg   <= SRC_WORD;
            term_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            src_reg   <= src_next;
            term_reg  <= term_next;
        end
    end

    a_term_starts_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status.byte_zero) |=> (state_reg == ST_PREP))
        else $error("terminator did not start a round");

    a_round_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |=> (state_reg == ST_MULX) ##1 (state_reg == ST_MULY)
        ##1 (state_reg == ST_FINY))
        else $error("word round steps out of order");

    a_finish_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("hash loaded while output register busy");

    a_no_intake_in_round: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_byte |-> (state_reg == ST_IDLE) && !status.byte_zero)
        else $error("byte packed outside idle");

endmodule

// ----- hw/rtl/anh_dp.sv -----
// datapath: byte folding and packing, word round with shared multiplier, output register
module anh_dp #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic [7:0]           s_tdata,
    output logic [31:0]          m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  anh_pkg::anh_cmd_t    cmd,
    output anh_pkg::anh_status_t status
);
    import anh_pkg::*;

    localparam int CW = $clog2(MAX_NAME_BYTES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_NAME_BYTES);

    logic          fold_reg;
    logic [31:0]   x_reg, y_reg, key_reg, word_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   xm_reg, ym_reg, sel1_reg, sel2_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   hash_reg;
    logic          valid_reg;

    logic [7:0]    folded;
    logic          room;
    logic [31:0]   round_word, key_rot, w_val, xm_val, ym_val;
    logic [31:0]   mul_a, mul_b;
    logic [32:0]   xs, ys;
    logic [31:0]   x_new, y_new;

    assign room = (count_reg < COUNT_MAX);

    always_comb begin
        folded = s_tdata;
        if (fold_reg) begin
            if (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_Z) begin
                folded = s_tdata + CASE_OFFSET;
            end else if (s_tdata == CHAR_SLASH) begin
                folded = CHAR_BSLASH;
            end
        end
    end

    assign status.byte_zero = (s_tdata == 8'd0);
    assign status.word_full = room && (count_reg[1:0] == 2'b11);
    assign status.partial   = (count_reg[1:0] != 2'b00);
    assign status.out_free  = !valid_reg || m_tready;

    always_comb begin
        case (cmd.src)
            SRC_WORD:  round_word = word_reg;
            SRC_TAIL0: round_word = TAIL_WORD_0;
            default:   round_word = TAIL_WORD_1;
        endcase
    end

    assign key_rot = {key_reg[30:0], key_reg[31]};
    assign w_val   = W_BASE ^ key_rot;
    assign xm_val  = x_reg ^ round_word;
    assign ym_val  = y_reg ^ round_word;

    assign mul_a = cmd.mulx ? xm_reg : ym_reg;
    assign mul_b = cmd.mulx ? sel1_reg : sel2_reg;

    // x: lo + hi + (hi != 0), end-around carry
    assign xs    = {1'b0, prod_reg[31:0]} + {1'b0, prod_reg[63:32]}
                 + {32'd0, (prod_reg[63:32] != 32'd0)};
    assign x_new = xs[31:0] + {31'd0, xs[32]};
    // y: lo + 2*hi + hi[31], plus two on carry out
    assign ys    = {1'b0, prod_reg[31:0]} + {1'b0, prod_reg[62:32], 1'b0}
                 + {32'd0, prod_reg[63]};
    assign y_new = ys[31:0] + {30'd0, ys[32], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg  <= 1'b1;
            x_reg     <= X_INIT;
            y_reg     <= Y_INIT;
            key_reg   <= KEY_INIT;
            word_reg  <= 32'd0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fold_reg <= cfg_wr_data;
            end
            if (cmd.take_byte && room) begin
                word_reg  <= word_reg | ({24'd0, folded} << {count_reg[1:0], 3'b000});
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.prep) begin
                key_reg <= key_rot;
                if (cmd.src == SRC_WORD) begin
                    word_reg <= 32'd0;
                end
            end
            if (cmd.muly) begin
                x_reg <= x_new;
            end
            if (cmd.finy) begin
                y_reg <= y_new;
            end
            if (cmd.finish) begin
                x_reg     <= X_INIT;
                y_reg     <= Y_INIT;
                key_reg   <= KEY_INIT;
                word_reg  <= 32'd0;
                count_reg <= '0;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            xm_reg   <= xm_val;
            ym_reg   <= ym_val;
            sel1_reg <= ((w_val + ym_val) | MASK_A) & MASK_C;
            sel2_reg <= ((w_val + xm_val) | MASK_B) & MASK_D;
        end
        if (cmd.mulx || cmd.muly) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.finish) begin
            hash_reg <= x_reg ^ y_reg;
        end
    end

    assign m_tdata  = hash_reg;
    assign m_tvalid = valid_reg;

endmodule

// ----- hw/rtl/archive_name_hash_top.sv -----
// top level of the archive name hash block
//
// name bytes enter on the s_ stream, one byte per request; a zero byte ends
// the name and produces one 32-bit hash on the m_ stream. fold_names is set
// through cfg_wr_en / cfg_wr_data (reset value 1); the user must write it
// only while the block is idle, as the block itself does not enforce this.
// a byte that does not complete a word is taken while the block stays idle;
// a byte completing a 4-byte word also starts a word round, and no byte is
// taken until that round ends. each word round runs its two 32x32 products
// through one shared multiplier over 4 steps. the terminator runs 2 or 3
// rounds, then the hash is loaded into the output register when it is free.
// bytes beyond MAX_NAME_BYTES are accepted and dropped until the terminator.
// reset clears the name state, sets fold_names and empties the output.
// when the receiver stalls, the hash waits in the output register while the
// next name is taken in; only the following hash waits for the slot.
module archive_name_hash_top #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // fold_names
    // name byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] name_byte
    // hash stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // [31:0] hash_value
);
    import anh_pkg::*;

    anh_cmd_t    cmd;     // controller to datapath
    anh_status_t status;  // datapath to controller

    // sequencing of intake and word rounds
    anh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // folding, packing, round arithmetic and output register
    anh_dp #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
